// File: design/assert_macros.svh
// Assertion macros shared by the checker files of the Ising lattice block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle: when pre holds, post must hold too.
`define CHK_SAME(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication: when pre holds, post must hold next cycle.
`define CHK_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: design/imf_pkg.sv
// Shared constants, types and register codes of the Ising Metropolis lattice block.
// No dependencies; used by ising_metropolis_flip and imf_checker.
package imf_pkg;

    // Lattice edge length. The site index logic relies on a power of two up to 256.
    localparam int SIDE  = 256;
    localparam int IDX_W = $clog2(SIDE);

    // Field widths of the stream payloads.
    localparam int ROW_W  = 8;
    localparam int COL_W  = 8;
    localparam int UNI_W  = 16;
    localparam int MAG_W  = 18;
    localparam int NRG_W  = 19;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 40;
    localparam int THR_W  = 16;
    localparam int CFG_IDX_W = 8;

    // Bit offsets inside the input and output tdata words.
    localparam int IN_COL_LSB  = ROW_W;
    localparam int IN_UNI_LSB  = ROW_W + COL_W;
    localparam int OUT_MAG_LSB = 1;
    localparam int OUT_NRG_LSB = 1 + MAG_W;

    // Reset values of the running totals: all spins up, every bond aligned.
    localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(SIDE * SIDE);
    localparam logic signed [NRG_W-1:0] NRG_RESET = NRG_W'(-2 * SIDE * SIDE);

    // Reset values of the acceptance thresholds.
    localparam logic [THR_W-1:0] THR4_RESET = THR_W'(11246);
    localparam logic [THR_W-1:0] THR8_RESET = THR_W'(1929);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THR4 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THR8 = CFG_IDX_W'(1);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

endpackage

// File: design/ising_metropolis_flip.sv
// Usage notes for the Ising lattice Metropolis block.
// Input stream (s_axis_*): one trial per transfer; tdata holds row, column and a 16-bit
// uniform random number. Output stream (m_axis_*): one result per trial with the flip
// flag and the running magnetization and energy totals after that trial.
// Configuration channel (i_cfg_*): writes the acceptance thresholds for dE of 4 and 8;
// it is always ready and should be used only while no trial is in flight.
// The lattice is one memory of SIDE rows, SIDE spins wide, with two read ports.
// The neighbor rows above and below are read in the input transfer cycle, the site
// row next (ST_READ), and ST_UPDATE decides, writes the row back and loads the output
// register. The input is ready again in the cycle after that, so a new trial is taken
// only after the last one has committed.
// After reset a clearing pass writes every row to all spins up, one row a cycle, over
// all SIDE (256) rows; s_axis_tready stays low during that pass.
// If the receiver stalls, the finished result waits in the output register and the
// next trial still runs up to its decision; it then holds until the register frees.
// Depends on imf_pkg.
module ising_metropolis_flip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata fields from bit 0: row[7:0], col[15:8], uniform[31:16]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [imf_pkg::IN_W-1:0]      s_axis_tdata,
    // tdata fields from bit 0: flipped[0], magnetization_sum[18:1],
    // energy_sum[37:19], zero pad[39:38]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [imf_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [imf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [imf_pkg::THR_W-1:0]     i_cfg_data
);

    localparam int IW = imf_pkg::IDX_W;
    localparam int SD = imf_pkg::SIDE;

    // Lattice memory, one row of spins per word, 1 means spin up.
    logic [SD-1:0] r_spin_mem [SD];

    // Sequencer and control registers.
    imf_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_clr_row;
    logic            r_out_valid;

    // Trial registers.
    logic [IW-1:0]                r_row, r_col;
    logic [imf_pkg::UNI_W-1:0]    r_unif;
    logic                         r_up_bit;
    logic [SD-1:0]                r_q_a, r_q_b;
    logic [imf_pkg::THR_W-1:0]    r_thr4, r_thr8;
    logic signed [imf_pkg::MAG_W-1:0] r_mag;
    logic signed [imf_pkg::NRG_W-1:0] r_nrg;
    logic [imf_pkg::OUT_W-1:0]    r_out_data;

    // Sequencer outputs.
    logic          s_accept;
    logic          rd_a_en, rd_b_en;
    logic [IW-1:0] rd_a_addr, rd_b_addr;
    logic          commit;
    logic          clr_we;

    // Input fields and their wrap-around neighbor rows.
    logic [IW-1:0] in_row, in_col, in_row_up, in_row_dn;

    // Decision logic.
    logic [IW-1:0] col_l, col_r;
    logic          site, left, right, down;
    logic [2:0]    aligned;
    logic          flip;
    logic signed [imf_pkg::NRG_W-1:0] d_nrg;
    logic signed [imf_pkg::MAG_W-1:0] d_mag;
    logic signed [imf_pkg::MAG_W-1:0] n_mag;
    logic signed [imf_pkg::NRG_W-1:0] n_nrg;
    logic [SD-1:0] flip_mask;

    assign in_row    = s_axis_tdata[IW-1:0];
    assign in_col    = s_axis_tdata[imf_pkg::IN_COL_LSB +: IW];
    // Power-of-two side: the index wraps on its own width.
    assign in_row_up = in_row - 1'b1;
    assign in_row_dn = in_row + 1'b1;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Next state and sequencer outputs.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        s_accept      = 1'b0;
        rd_a_en       = 1'b0;
        rd_b_en       = 1'b0;
        rd_a_addr     = in_row_up;
        rd_b_addr     = in_row_dn;
        commit        = 1'b0;
        clr_we        = 1'b0;
        case (r_state)
            imf_pkg::ST_CLEAR: begin
                clr_we = 1'b1;
                if (r_clr_row == IW'(SD - 1)) begin
                    n_state = imf_pkg::ST_IDLE;
                end
            end
            imf_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    s_accept = 1'b1;
                    rd_a_en  = 1'b1;
                    rd_b_en  = 1'b1;
                    n_state  = imf_pkg::ST_READ;
                end
            end
            imf_pkg::ST_READ: begin
                rd_a_en   = 1'b1;
                rd_a_addr = r_row;
                n_state   = imf_pkg::ST_UPDATE;
            end
            imf_pkg::ST_UPDATE: begin
                if (!r_out_valid || m_axis_tready) begin
                    commit  = 1'b1;
                    n_state = imf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = imf_pkg::ST_CLEAR;
            end
        endcase
    end

    // Spin of the site, its row neighbors and the count aligned with it.
    always_comb begin
        col_l   = r_col - 1'b1;
        col_r   = r_col + 1'b1;
        site    = r_q_a[r_col];
        left    = r_q_a[col_l];
        right   = r_q_a[col_r];
        down    = r_q_b[r_col];
        aligned = 3'({2'b00, r_up_bit ~^ site}) + 3'({2'b00, down ~^ site})
                + 3'({2'b00, left ~^ site}) + 3'({2'b00, right ~^ site});
        // dE = 4 * aligned - 8: three aligned is dE 4, four aligned is dE 8.
        case (aligned)
            3'd3:    flip = r_unif < r_thr4;
            3'd4:    flip = r_unif < r_thr8;
            default: flip = 1'b1;
        endcase
        d_nrg     = $signed({{(imf_pkg::NRG_W - 5){1'b0}}, aligned, 2'b00})
                  - imf_pkg::NRG_W'(8);
        d_mag     = site ? -imf_pkg::MAG_W'(2) : imf_pkg::MAG_W'(2);
        n_mag     = flip ? r_mag + d_mag : r_mag;
        n_nrg     = flip ? r_nrg + d_nrg : r_nrg;
        flip_mask = {{(SD - 1){1'b0}}, flip} << r_col;
    end

    // State register and clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= imf_pkg::ST_CLEAR;
            r_clr_row <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
        end
    end

    // Lattice memory writes: the clearing pass, then row write-back on commit.
    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            r_spin_mem[r_clr_row] <= '1;
        end else if (commit) begin
            r_spin_mem[r_row] <= r_q_a ^ flip_mask;
        end
    end

    // Lattice memory reads, registered; the data holds while the port is idle.
    always_ff @(posedge i_clk) begin
        if (rd_a_en) begin
            r_q_a <= r_spin_mem[rd_a_addr];
        end
        if (rd_b_en) begin
            r_q_b <= r_spin_mem[rd_b_addr];
        end
    end

    // Trial payload capture.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_row  <= in_row;
            r_col  <= in_col;
            r_unif <= s_axis_tdata[imf_pkg::IN_UNI_LSB +: imf_pkg::UNI_W];
        end
        // The row above arrives in the read cycle, before port A fetches the site row.
        if (r_state == imf_pkg::ST_READ) begin
            r_up_bit <= r_q_a[r_col];
        end
    end

    // Configuration registers and running totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr4 <= imf_pkg::THR4_RESET;
            r_thr8 <= imf_pkg::THR8_RESET;
            r_mag  <= imf_pkg::MAG_RESET;
            r_nrg  <= imf_pkg::NRG_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_index == imf_pkg::CFG_THR4) begin
                r_thr4 <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == imf_pkg::CFG_THR8) begin
                r_thr8 <= i_cfg_data;
            end
            if (commit) begin
                r_mag <= n_mag;
                r_nrg <= n_nrg;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= {2'b00, n_nrg, n_mag, flip};
        end
    end

endmodule

// File: design/imf_checker.sv
// Port-level checker for ising_metropolis_flip, attached by a bind statement.
// Depends on imf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [imf_pkg::OUT_W-1:0]     m_axis_tdata
);

    // A stalled result keeps its valid and its data.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // Trials are sequential: no input transfer in the cycle after one.
    `CHK_NEXT(a_in_gap, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after a transfer")

    // The clearing pass follows reset, so the input is not ready just after it.
    `CHK_NEXT(a_clear_after_reset, i_clk, 1'b1, !i_rst_n, !s_axis_tready, "input ready during the clearing pass")

    // Magnetization moves by two and energy by four, so their low bits stay zero.
    `CHK_SAME(a_total_parity, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[imf_pkg::OUT_MAG_LSB] == 1'b0) && (m_axis_tdata[imf_pkg::OUT_NRG_LSB +: 2] == 2'b00), "total with impossible low bits")

endmodule

bind ising_metropolis_flip imf_checker u_imf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/tb_ising_metropolis_flip.sv
// Self-checking testbench for the Ising lattice Metropolis block ising_metropolis_flip.
// Trials go in on the input stream, and results are checked against a lattice predictor.
// Depends on imf_pkg and the block's RTL only.
module tb_ising_metropolis_flip;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int MAX_REPORTS     = 10;

    // One result of a trial as the predictor expects it.
    typedef struct {
        logic                             flipped;
        logic signed [imf_pkg::MAG_W-1:0] magnetization;
        logic signed [imf_pkg::NRG_W-1:0] energy;
    } t_trial_result;

    // Clock, reset and every block input start at known values.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [imf_pkg::IN_W-1:0]      s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [imf_pkg::OUT_W-1:0]     m_axis_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [imf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [imf_pkg::THR_W-1:0]     i_cfg_data = '0;

    // Predicted lattice, totals and thresholds.
    bit                               spin_up [imf_pkg::SIDE][imf_pkg::SIDE];
    logic signed [imf_pkg::MAG_W-1:0] mag_total;
    logic signed [imf_pkg::NRG_W-1:0] nrg_total;
    logic [imf_pkg::THR_W-1:0]        thr_de4;
    logic [imf_pkg::THR_W-1:0]        thr_de8;

    // Trials waiting to be sent and results waiting to arrive.
    logic [imf_pkg::IN_W-1:0] pending_trials [$];
    t_trial_result            awaited_results [$];

    int trials_queued = 0;
    int trials_accepted = 0;
    int results_checked = 0;
    int flips_predicted = 0;
    int failures = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int hold_off_left;
    bit hold_off_armed = 1'b0;
    logic [imf_pkg::ROW_W-1:0] cluster_row = '0;
    logic [imf_pkg::COL_W-1:0] cluster_col = '0;

    ising_metropolis_flip dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int spin_value(int r, int c);
        return spin_up[r][c] ? 1 : -1;
    endfunction

    function automatic logic [imf_pkg::IN_W-1:0] trial_word(logic [imf_pkg::ROW_W-1:0] r,
                                                            logic [imf_pkg::COL_W-1:0] c,
                                                            logic [imf_pkg::UNI_W-1:0] u);
        return {u, c, r};
    endfunction

    task automatic report_failure(string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Metropolis trial on the predicted lattice; queues the result it must produce.
    task automatic metropolis_trial(logic [imf_pkg::IN_W-1:0] word);
        int                        r;
        int                        c;
        int                        s;
        int                        nb;
        int                        de;
        logic [imf_pkg::UNI_W-1:0] u;
        bit                        flip;
        t_trial_result             res;
        r  = int'(word[imf_pkg::ROW_W-1:0]) % imf_pkg::SIDE;
        c  = int'(word[imf_pkg::IN_COL_LSB +: imf_pkg::COL_W]) % imf_pkg::SIDE;
        u  = word[imf_pkg::IN_UNI_LSB +: imf_pkg::UNI_W];
        s  = spin_value(r, c);
        nb = spin_value((r + imf_pkg::SIDE - 1) % imf_pkg::SIDE, c)
           + spin_value((r + 1) % imf_pkg::SIDE, c)
           + spin_value(r, (c + imf_pkg::SIDE - 1) % imf_pkg::SIDE)
           + spin_value(r, (c + 1) % imf_pkg::SIDE);
        de = 2 * s * nb;
        if (de <= 0)
            flip = 1'b1;
        else if (de == 4)
            flip = (u < thr_de4);
        else
            flip = (u < thr_de8);
        if (flip) begin
            spin_up[r][c] = !spin_up[r][c];
            mag_total = mag_total - imf_pkg::MAG_W'(2 * s);
            nrg_total = nrg_total + imf_pkg::NRG_W'(de);
            flips_predicted++;
        end
        res.flipped       = flip;
        res.magnetization = mag_total;
        res.energy        = nrg_total;
        awaited_results.push_back(res);
    endtask

    // Compare one output transfer with the oldest expected result.
    task automatic check_result(logic [imf_pkg::OUT_W-1:0] word);
        t_trial_result                    want;
        logic                             got_flip;
        logic signed [imf_pkg::MAG_W-1:0] got_mag;
        logic signed [imf_pkg::NRG_W-1:0] got_nrg;
        got_flip = word[0];
        got_mag  = word[imf_pkg::OUT_MAG_LSB +: imf_pkg::MAG_W];
        got_nrg  = word[imf_pkg::OUT_NRG_LSB +: imf_pkg::NRG_W];
        results_checked++;
        if (awaited_results.size() == 0) begin
            report_failure($sformatf("unexpected result flip=%0d mag=%0d energy=%0d",
                                     got_flip, got_mag, got_nrg));
        end else begin
            want = awaited_results.pop_front();
            if (got_flip !== want.flipped || got_mag !== want.magnetization ||
                got_nrg !== want.energy)
                report_failure($sformatf(
                    "result %0d: expected flip=%0d mag=%0d energy=%0d, got flip=%0d mag=%0d energy=%0d",
                    results_checked, want.flipped, want.magnetization, want.energy,
                    got_flip, got_mag, got_nrg));
        end
    endtask

    // Input driver: offers queued trials and predicts each one on its transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                metropolis_trial(s_axis_tdata);
                trials_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_trials.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_trials.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result transfer and drives a random ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            m_axis_tready <= (hold_off_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Long receiver hold-off, counted down here once armed.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_off_left <= 0;
        else if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
        else if (hold_off_armed)
            hold_off_left <= HOLD_OFF_CYCLES;
    end

    task automatic queue_trial(logic [imf_pkg::IN_W-1:0] word);
        pending_trials.push_back(word);
        trials_queued++;
    endtask

    // Wait until every trial has gone in and every result has come out.
    task automatic wait_until_idle();
        while (!(trials_accepted == trials_queued && awaited_results.size() == 0))
            @(negedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(logic [imf_pkg::CFG_IDX_W-1:0] idx,
                                  logic [imf_pkg::THR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == imf_pkg::CFG_THR4)
            thr_de4 = value;
        else
            thr_de8 = value;
    endtask

    task automatic set_thresholds(logic [imf_pkg::THR_W-1:0] t4, logic [imf_pkg::THR_W-1:0] t8);
        wait_until_idle();
        write_register(imf_pkg::CFG_THR4, t4);
        write_register(imf_pkg::CFG_THR8, t8);
    endtask

    // Random trial: mostly a small window of sites so that neighbors interact,
    // with uniforms often placed right at a threshold.
    function automatic logic [imf_pkg::IN_W-1:0] random_trial();
        logic [imf_pkg::ROW_W-1:0] r;
        logic [imf_pkg::COL_W-1:0] c;
        logic [imf_pkg::UNI_W-1:0] u;
        if ($urandom_range(0, 3) != 0) begin
            r = cluster_row + imf_pkg::ROW_W'($urandom_range(0, 3));
            c = cluster_col + imf_pkg::COL_W'($urandom_range(0, 3));
        end else begin
            r = imf_pkg::ROW_W'($urandom());
            c = imf_pkg::COL_W'($urandom());
        end
        case ($urandom_range(0, 3))
            0:       u = thr_de4 + imf_pkg::UNI_W'($urandom_range(0, 3)) - imf_pkg::UNI_W'(2);
            1:       u = thr_de8 + imf_pkg::UNI_W'($urandom_range(0, 3)) - imf_pkg::UNI_W'(2);
            default: u = imf_pkg::UNI_W'($urandom());
        endcase
        return trial_word(r, c, u);
    endfunction

    // One random phase; the window moves every 50 trials, sometimes across the wrap.
    task automatic run_random_phase(int n, int send_pct, int recv_pct, bit long_hold);
        @(negedge i_clk);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                cluster_row = ($urandom_range(0, 2) == 0) ? imf_pkg::ROW_W'(imf_pkg::SIDE - 2)
                                                          : imf_pkg::ROW_W'($urandom());
                cluster_col = ($urandom_range(0, 2) == 0) ? imf_pkg::COL_W'(imf_pkg::SIDE - 2)
                                                          : imf_pkg::COL_W'($urandom());
            end
            queue_trial(random_trial());
        end
        if (long_hold) begin
            while (trials_accepted < trials_queued - n / 2)
                @(negedge i_clk);
            hold_off_armed = 1'b1;
            @(posedge i_clk);
            @(negedge i_clk);
            hold_off_armed = 1'b0;
        end
        wait_until_idle();
    endtask

    // Stimulus sequence.
    initial begin
        foreach (spin_up[r, c])
            spin_up[r][c] = 1'b1;
        mag_total = imf_pkg::MAG_RESET;
        nrg_total = imf_pkg::NRG_RESET;
        thr_de4   = imf_pkg::THR4_RESET;
        thr_de8   = imf_pkg::THR8_RESET;
        sender_idle_pct   = 10;
        receiver_idle_pct = 49;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Thresholds at full scale: only a uniform of all ones rejects.
        set_thresholds('1, '1);
        @(negedge i_clk);
        queue_trial(trial_word(0, 0, 0));                // dE of 8 accepted
        queue_trial(trial_word(0, 0, '1));               // dE of -8 flips whatever uniform is
        queue_trial(trial_word(0, 0, 0));
        queue_trial(trial_word(0, imf_pkg::SIDE - 1, '1));        // dE of 4 rejected, column wrap
        queue_trial(trial_word(0, imf_pkg::SIDE - 1, 100));
        queue_trial(trial_word(imf_pkg::SIDE - 1, 0, '1));        // row wrap
        queue_trial(trial_word(imf_pkg::SIDE - 1, 0, 0));
        queue_trial(trial_word(imf_pkg::SIDE - 1, imf_pkg::SIDE - 1, '1)); // dE of zero flips
        queue_trial(trial_word(imf_pkg::SIDE - 1, imf_pkg::SIDE - 1, '1));
        queue_trial(trial_word(imf_pkg::SIDE - 2, imf_pkg::SIDE - 1, 0));
        queue_trial(trial_word(imf_pkg::SIDE - 1, imf_pkg::SIDE - 1, '1)); // dE of -4 flips
        queue_trial(trial_word(imf_pkg::SIDE - 1, imf_pkg::SIDE - 1, '1)); // dE of 4 rejected

        // Zero thresholds: no uphill move is ever accepted.
        set_thresholds('0, '0);
        @(negedge i_clk);
        queue_trial(trial_word(1, 0, 0));
        queue_trial(trial_word(100, 200, 0));

        // Acceptance is strictly below the threshold.
        set_thresholds(imf_pkg::THR_W'(1000), imf_pkg::THR_W'(1));
        @(negedge i_clk);
        queue_trial(trial_word(0, 1, 1000));
        queue_trial(trial_word(0, 1, 999));
        queue_trial(trial_word(50, 50, 1));
        queue_trial(trial_word(50, 50, 0));

        set_thresholds(imf_pkg::THR4_RESET, imf_pkg::THR8_RESET);
        run_random_phase(200, 10, 49, 1'b1);
        set_thresholds(imf_pkg::THR_W'($urandom()), imf_pkg::THR_W'($urandom()));
        run_random_phase(200, 49, 10, 1'b0);
        set_thresholds(imf_pkg::THR_W'($urandom()), imf_pkg::THR_W'($urandom()));
        run_random_phase(200, 0, 0, 1'b1);

        wait_until_idle();
        repeat (20) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_failure($sformatf("%0d results never arrived", awaited_results.size()));
        $display("Ran %0d trials with %0d flips and %0d results checked, over six threshold",
                 trials_accepted, flips_predicted, results_checked);
        $display("settings, stalls on both sides and long receiver hold-offs; %0d failures.",
                 failures);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("Timeout: %0d trials sent, %0d results checked", trials_accepted,
                 results_checked);
        $display("Some tests failed");
        $finish;
    end

endmodule
